// ===== hdl/eecu_pkg.sv =====
// ----------------------------------------------------------------------------
// eecu_pkg
// Widths, stage counts, mode codes and helpers shared by the edge endpoint
// clipper unit and its sub-blocks.
// ----------------------------------------------------------------------------
package eecu_pkg;

    // Field widths
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;

    // Derived arithmetic widths
    localparam int R_W    = SIZE_W - 1;        // radius / half size
    localparam int D_W    = COORD_W + 1;       // signed centre delta
    localparam int A_W    = COORD_W;           // magnitude of a delta
    localparam int PROD_W = SIZE_W + A_W;      // aspect cross products
    localparam int RA_W   = R_W + A_W;         // radius times delta
    localparam int SQ_W   = 2 * A_W;           // squared delta
    localparam int DSQ_W  = SQ_W + 1;          // dx^2 + dy^2
    localparam int T_W    = 2 * RA_W;          // (r*|d|)^2
    localparam int QD_W   = R_W + DSQ_W;       // q * dsq
    localparam int C_W    = T_W + 3;           // root candidate
    localparam int N_W    = R_W + A_W;         // straight-clip numerator
    localparam int SUM_W  = N_W + 2;           // point before saturation

    // Pipeline depths
    localparam int DIV_STG  = N_W;             // one quotient bit per stage
    localparam int ROOT_STG = R_W;             // one root bit per stage
    localparam int LANE_LAT = 4 + DIV_STG;     // registers through a lane

    // Attach modes
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_STRAIGHT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CIRCLE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MID      = 2'd2;

    // Register file
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_ATTACH_MODE = '0;

    // Per-item lane control
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              dir_e;   // leave toward east when the side is E/W
        logic              dir_s;   // leave toward south when the side is N/S
    } lane_ctl_t;

    // Magnitude of a signed delta
    function automatic logic [A_W-1:0] abs_d(input logic signed [D_W-1:0] v);
        return v[D_W-1] ? A_W'(-v) : A_W'(v);
    endfunction

    // Clamp to the signed coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
        lo = -hi - SUM_W'(1);
        if (v > hi) begin
            return hi[COORD_W-1:0];
        end else if (v < lo) begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

// ===== hdl/edge_endpoint_clipper_unit.sv =====
// ----------------------------------------------------------------------------
// edge_endpoint_clipper_unit
// Clips the edge between two node centres to their boxes: one lane per
// endpoint, results merged into one output register.
// ----------------------------------------------------------------------------
//   channel   | ports               | carries
//   ----------+---------------------+-------------------------------------
//   input     | s_valid / s_ready   | two centres, two boxes
//   result    | m_valid / m_ready   | start and end points
//   config    | psel / penable ...  | attach_mode at byte address 0
//
// One item per cycle while the output is not stalled; the depth from acceptance
// to result is dominated by the 30-stage quotient pipeline of the straight clip.
// Reset (aresetn low at a clock edge) clears the valid pipe and attach_mode.
// While a result waits on m_ready the whole pipeline holds and s_ready is low;
// s_ready is high whenever the output register is empty or being taken.
// ----------------------------------------------------------------------------
module edge_endpoint_clipper_unit import eecu_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input items
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_center1_x,
    input  logic signed [COORD_W-1:0] s_center1_y,
    input  logic signed [COORD_W-1:0] s_center2_x,
    input  logic signed [COORD_W-1:0] s_center2_y,
    input  logic signed [COORD_W-1:0] s_box1_left,
    input  logic signed [COORD_W-1:0] s_box1_top,
    input  logic [SIZE_W-1:0]         s_box1_width,
    input  logic [SIZE_W-1:0]         s_box1_height,
    input  logic signed [COORD_W-1:0] s_box2_left,
    input  logic signed [COORD_W-1:0] s_box2_top,
    input  logic [SIZE_W-1:0]         s_box2_width,
    input  logic [SIZE_W-1:0]         s_box2_height,
    // result items
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_start_x,
    output logic signed [COORD_W-1:0] m_start_y,
    output logic signed [COORD_W-1:0] m_end_x,
    output logic signed [COORD_W-1:0] m_end_y,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    // ---------------- configuration ----------------
    logic [MODE_W-1:0] mode_reg;
    logic              sel_mode;

    assign pready   = 1'b1;
    assign sel_mode = paddr[ADDR_W-1:2] == REG_ATTACH_MODE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_STRAIGHT;
        end else if (psel && penable && pwrite && pready && sel_mode) begin
            mode_reg <= pwdata[MODE_W-1:0];
        end
    end

    assign prdata = sel_mode ? DATA_W'(mode_reg) : '0;

    // ---------------- pipeline control ----------------
    logic                m_valid_reg;
    logic [LANE_LAT-1:0] vld_reg;
    logic                en;

    // Advance everything unless a finished item is stuck at the output
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[LANE_LAT-2:0], s_valid};
            m_valid_reg <= vld_reg[LANE_LAT-1];
        end
    end

    // ---------------- lanes ----------------
    lane_ctl_t ctl1, ctl2;
    logic      right, lower;

    assign right = s_center2_x > s_center1_x;
    assign lower = s_center2_y > s_center1_y;

    // Ties send the start west/north and the end east/south
    assign ctl1 = '{mode: mode_reg, dir_e: right,  dir_s: lower};
    assign ctl2 = '{mode: mode_reg, dir_e: !right, dir_s: !lower};

    logic signed [COORD_W-1:0] p1_x, p1_y, p2_x, p2_y;

    eecu_lane u_lane_start (
        .clk(aclk), .en(en), .ctl(ctl1),
        .self_x(s_center1_x), .self_y(s_center1_y),
        .other_x(s_center2_x), .other_y(s_center2_y),
        .org_x(s_box1_left), .org_y(s_box1_top),
        .size_w(s_box1_width), .size_h(s_box1_height),
        .pt_x(p1_x), .pt_y(p1_y)
    );

    eecu_lane u_lane_end (
        .clk(aclk), .en(en), .ctl(ctl2),
        .self_x(s_center2_x), .self_y(s_center2_y),
        .other_x(s_center1_x), .other_y(s_center1_y),
        .org_x(s_box2_left), .org_y(s_box2_top),
        .size_w(s_box2_width), .size_h(s_box2_height),
        .pt_x(p2_x), .pt_y(p2_y)
    );

    // ---------------- merge into the output register ----------------
    logic signed [COORD_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg <= p1_x;
            sy_reg <= p1_y;
            ex_reg <= p2_x;
            ey_reg <= p2_y;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_start_x = sx_reg;
    assign m_start_y = sy_reg;
    assign m_end_x   = ex_reg;
    assign m_end_y   = ey_reg;

endmodule

// ===== hdl/eecu_delay.sv =====
// ----------------------------------------------------------------------------
// eecu_delay
// Fixed-depth shift line that holds side data level with a long unit.
// ----------------------------------------------------------------------------
module eecu_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [DEPTH];

    // Advance all taps together
    always_ff @(posedge clk) begin
        if (en) begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// ===== hdl/eecu_div.sv =====
// ----------------------------------------------------------------------------
// eecu_div
// Pipelined restoring divider, unsigned, one quotient bit per stage.
// ----------------------------------------------------------------------------
module eecu_div import eecu_pkg::*; (
    input  logic           clk,
    input  logic           en,
    input  logic [N_W-1:0] num,
    input  logic [A_W-1:0] den,
    output logic [N_W-1:0] quo
);

    logic [A_W-1:0] rem_reg [DIV_STG];
    logic [N_W-1:0] nq_reg  [DIV_STG];
    logic [A_W-1:0] den_reg [DIV_STG];

    for (genvar g = 0; g < DIV_STG; g++) begin : g_stage
        logic [A_W-1:0] rem_in;
        logic [N_W-1:0] nq_in;
        logic [A_W-1:0] den_in;
        logic [A_W:0]   sh;
        logic           ge;

        if (g == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
        end else begin : g_next
            assign rem_in = rem_reg[g-1];
            assign nq_in  = nq_reg[g-1];
            assign den_in = den_reg[g-1];
        end

        // Bring down the next numerator bit and try a subtract
        assign sh = {rem_in, nq_in[N_W-1]};
        assign ge = sh >= {1'b0, den_in};

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[g] <= ge ? A_W'(sh - {1'b0, den_in}) : sh[A_W-1:0];
                nq_reg[g]  <= {nq_in[N_W-2:0], ge};
                den_reg[g] <= den_in;
            end
        end
    end

    assign quo = nq_reg[DIV_STG-1];

endmodule

// ===== hdl/eecu_root.sv =====
// ----------------------------------------------------------------------------
// eecu_root
// Pipelined search for the largest q with q*q*dsq <= tgt, one bit per stage.
// q*q*dsq is kept incrementally, so each stage only shifts, adds, compares.
// ----------------------------------------------------------------------------
module eecu_root import eecu_pkg::*; (
    input  logic             clk,
    input  logic             en,
    input  logic [T_W-1:0]   tgt,
    input  logic [DSQ_W-1:0] dsq,
    output logic [R_W-1:0]   q
);

    logic [T_W-1:0]   s_reg   [ROOT_STG];
    logic [QD_W-1:0]  qd_reg  [ROOT_STG];
    logic [R_W-1:0]   q_reg   [ROOT_STG];
    logic [T_W-1:0]   tgt_reg [ROOT_STG];
    logic [DSQ_W-1:0] dsq_reg [ROOT_STG];

    for (genvar g = 0; g < ROOT_STG; g++) begin : g_stage
        localparam int K = ROOT_STG - 1 - g;
        logic [T_W-1:0]   s_in;
        logic [QD_W-1:0]  qd_in;
        logic [R_W-1:0]   q_in;
        logic [T_W-1:0]   tgt_in;
        logic [DSQ_W-1:0] dsq_in;
        logic [C_W-1:0]   cand;
        logic             fit;

        if (g == 0) begin : g_first
            assign s_in   = '0;
            assign qd_in  = '0;
            assign q_in   = '0;
            assign tgt_in = tgt;
            assign dsq_in = dsq;
        end else begin : g_next
            assign s_in   = s_reg[g-1];
            assign qd_in  = qd_reg[g-1];
            assign q_in   = q_reg[g-1];
            assign tgt_in = tgt_reg[g-1];
            assign dsq_in = dsq_reg[g-1];
        end

        // (q + 2^K)^2 * dsq = q^2*dsq + 2^(K+1)*q*dsq + 2^(2K)*dsq
        assign cand = C_W'(s_in) + (C_W'(qd_in) << (K + 1)) + (C_W'(dsq_in) << (2 * K));
        assign fit  = cand <= C_W'(tgt_in);

        always_ff @(posedge clk) begin
            if (en) begin
                s_reg[g]   <= fit ? cand[T_W-1:0] : s_in;
                qd_reg[g]  <= fit ? qd_in + (QD_W'(dsq_in) << K) : qd_in;
                q_reg[g]   <= fit ? (q_in | (R_W'(1) << K)) : q_in;
                tgt_reg[g] <= tgt_in;
                dsq_reg[g] <= dsq_in;
            end
        end
    end

    assign q = q_reg[ROOT_STG-1];

endmodule

// ===== hdl/eecu_lane.sv =====
// ----------------------------------------------------------------------------
// eecu_lane
// One endpoint: side choice, straight clip, circle clip and side midpoint,
// all computed in a fixed-latency pipeline; the mode picks the result.
// ----------------------------------------------------------------------------
module eecu_lane import eecu_pkg::*; (
    input  logic                      clk,
    input  logic                      en,
    input  lane_ctl_t                 ctl,
    input  logic signed [COORD_W-1:0] self_x,
    input  logic signed [COORD_W-1:0] self_y,
    input  logic signed [COORD_W-1:0] other_x,
    input  logic signed [COORD_W-1:0] other_y,
    input  logic signed [COORD_W-1:0] org_x,
    input  logic signed [COORD_W-1:0] org_y,
    input  logic [SIZE_W-1:0]         size_w,
    input  logic [SIZE_W-1:0]         size_h,
    output logic signed [COORD_W-1:0] pt_x,
    output logic signed [COORD_W-1:0] pt_y
);

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic                      ew;
        logic                      qneg;
        logic                      skip;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [D_W-1:0]     fix;
        logic signed [D_W-1:0]     mid_x;
        logic signed [D_W-1:0]     mid_y;
        logic                      xneg;
        logic                      xzero;
        logic                      yneg;
        logic                      yzero;
    } side_t;

    // ---------------- stage 1: capture the item ----------------
    lane_ctl_t                 ctl1_reg;
    logic signed [COORD_W-1:0] sx1_reg, sy1_reg, ox1_reg, oy1_reg, orgx1_reg, orgy1_reg;
    logic [SIZE_W-1:0]         w1_reg, h1_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            ctl1_reg  <= ctl;
            sx1_reg   <= self_x;
            sy1_reg   <= self_y;
            ox1_reg   <= other_x;
            oy1_reg   <= other_y;
            orgx1_reg <= org_x;
            orgy1_reg <= org_y;
            w1_reg    <= size_w;
            h1_reg    <= size_h;
        end
    end

    logic signed [D_W-1:0] dx1, dy1;
    logic [A_W-1:0]        adx1, ady1;
    logic [R_W-1:0]        r1;

    assign dx1  = D_W'(ox1_reg) - D_W'(sx1_reg);
    assign dy1  = D_W'(oy1_reg) - D_W'(sy1_reg);
    assign adx1 = abs_d(dx1);
    assign ady1 = abs_d(dy1);
    assign r1   = (w1_reg > h1_reg) ? w1_reg[SIZE_W-1:1] : h1_reg[SIZE_W-1:1];

    // ---------------- stage 2: products ----------------
    lane_ctl_t                 ctl2_reg;
    logic signed [COORD_W-1:0] sx2_reg, sy2_reg, orgx2_reg, orgy2_reg;
    logic [SIZE_W-1:0]         w2_reg, h2_reg;
    logic signed [D_W-1:0]     dx2_reg, dy2_reg;
    logic [PROD_W-1:0]         ph2_reg, pw2_reg;
    logic [RA_W-1:0]           rax2_reg, ray2_reg;
    logic [SQ_W-1:0]           sqx2_reg, sqy2_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            ctl2_reg  <= ctl1_reg;
            sx2_reg   <= sx1_reg;
            sy2_reg   <= sy1_reg;
            orgx2_reg <= orgx1_reg;
            orgy2_reg <= orgy1_reg;
            w2_reg    <= w1_reg;
            h2_reg    <= h1_reg;
            dx2_reg   <= dx1;
            dy2_reg   <= dy1;
            ph2_reg   <= PROD_W'(h1_reg) * PROD_W'(adx1);
            pw2_reg   <= PROD_W'(w1_reg) * PROD_W'(ady1);
            rax2_reg  <= RA_W'(r1) * RA_W'(adx1);
            ray2_reg  <= RA_W'(r1) * RA_W'(ady1);
            sqx2_reg  <= SQ_W'(adx1) * SQ_W'(adx1);
            sqy2_reg  <= SQ_W'(ady1) * SQ_W'(ady1);
        end
    end

    // ---------------- stage 3: side choice, circle targets ----------------
    lane_ctl_t                 ctl3_reg;
    logic signed [COORD_W-1:0] sx3_reg, sy3_reg, orgx3_reg, orgy3_reg;
    logic [SIZE_W-1:0]         w3_reg, h3_reg;
    logic signed [D_W-1:0]     dx3_reg, dy3_reg;
    logic                      ew3_reg;
    logic [T_W-1:0]            tx3_reg, ty3_reg;
    logic [DSQ_W-1:0]          dsq3_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            ctl3_reg  <= ctl2_reg;
            sx3_reg   <= sx2_reg;
            sy3_reg   <= sy2_reg;
            orgx3_reg <= orgx2_reg;
            orgy3_reg <= orgy2_reg;
            w3_reg    <= w2_reg;
            h3_reg    <= h2_reg;
            dx3_reg   <= dx2_reg;
            dy3_reg   <= dy2_reg;
            ew3_reg   <= ph2_reg > pw2_reg;
            tx3_reg   <= T_W'(rax2_reg) * T_W'(rax2_reg);
            ty3_reg   <= T_W'(ray2_reg) * T_W'(ray2_reg);
            dsq3_reg  <= DSQ_W'(sqx2_reg) + DSQ_W'(sqy2_reg);
        end
    end

    // Circle steps for both coordinates
    logic [R_W-1:0] qx_c, qy_c;

    eecu_root u_root_x (.clk(clk), .en(en), .tgt(tx3_reg), .dsq(dsq3_reg), .q(qx_c));
    eecu_root u_root_y (.clk(clk), .en(en), .tgt(ty3_reg), .dsq(dsq3_reg), .q(qy_c));

    // ---------------- stage 4: straight setup, midpoint ----------------
    logic                  sneg;
    logic [R_W-1:0]        half;
    logic signed [D_W-1:0] hs, da, db, base, hw, hh, wfull, hfull;
    side_t                 side4;

    always_comb begin
        sneg  = ew3_reg ? !ctl3_reg.dir_e : !ctl3_reg.dir_s;
        half  = ew3_reg ? w3_reg[SIZE_W-1:1] : h3_reg[SIZE_W-1:1];
        hs    = D_W'(half);
        da    = ew3_reg ? dy3_reg : dx3_reg;
        db    = ew3_reg ? dx3_reg : dy3_reg;
        base  = ew3_reg ? D_W'(sx3_reg) : D_W'(sy3_reg);
        hw    = D_W'(w3_reg[SIZE_W-1:1]);
        hh    = D_W'(h3_reg[SIZE_W-1:1]);
        wfull = D_W'(w3_reg);
        hfull = D_W'(h3_reg);

        side4.mode  = ctl3_reg.mode;
        side4.ew    = ew3_reg;
        side4.qneg  = sneg ^ da[D_W-1] ^ db[D_W-1];
        side4.skip  = (da == '0) || (db == '0);
        side4.sx    = sx3_reg;
        side4.sy    = sy3_reg;
        side4.fix   = sneg ? base - hs : base + hs;
        // Midpoint of the chosen side
        if (ew3_reg) begin
            side4.mid_x = D_W'(orgx3_reg) + (sneg ? D_W'(0) : wfull);
            side4.mid_y = D_W'(orgy3_reg) + hh;
        end else begin
            side4.mid_x = D_W'(orgx3_reg) + hw;
            side4.mid_y = D_W'(orgy3_reg) + (sneg ? D_W'(0) : hfull);
        end
        side4.xneg  = dx3_reg[D_W-1];
        side4.xzero = dx3_reg == '0;
        side4.yneg  = dy3_reg[D_W-1];
        side4.yzero = dy3_reg == '0;
    end

    logic [N_W-1:0] num4_reg;
    logic [A_W-1:0] den4_reg;
    side_t          side4_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            num4_reg  <= N_W'(half) * N_W'(abs_d(da));
            den4_reg  <= abs_d(db);
            side4_reg <= side4;
        end
    end

    // Quotient for the sideways step
    logic [N_W-1:0] quo;

    eecu_div u_div (.clk(clk), .en(en), .num(num4_reg), .den(den4_reg), .quo(quo));

    // Hold side data and circle steps level with the quotient
    side_t          side_e;
    logic [R_W-1:0] qx_e, qy_e;

    eecu_delay #(.W($bits(side_t)), .DEPTH(DIV_STG)) u_dly_side (
        .clk(clk), .en(en), .din(side4_reg), .dout(side_e)
    );

    eecu_delay #(.W(2 * R_W), .DEPTH(DIV_STG + 1 - ROOT_STG)) u_dly_root (
        .clk(clk), .en(en), .din({qx_c, qy_c}), .dout({qx_e, qy_e})
    );

    // ---------------- final select ----------------
    logic signed [SUM_W-1:0] step, sx_e, sy_e, cqx, cqy, res_x, res_y;

    always_comb begin
        sx_e = SUM_W'(side_e.sx);
        sy_e = SUM_W'(side_e.sy);
        if (side_e.skip) begin
            step = '0;
        end else begin
            step = side_e.qneg ? -SUM_W'(quo) : SUM_W'(quo);
        end
        cqx = side_e.xzero ? SUM_W'(0) : (side_e.xneg ? -SUM_W'(qx_e) : SUM_W'(qx_e));
        cqy = side_e.yzero ? SUM_W'(0) : (side_e.yneg ? -SUM_W'(qy_e) : SUM_W'(qy_e));

        case (side_e.mode)
            MODE_STRAIGHT: begin
                if (side_e.ew) begin
                    res_x = SUM_W'(side_e.fix);
                    res_y = sy_e + step;
                end else begin
                    res_x = sx_e + step;
                    res_y = SUM_W'(side_e.fix);
                end
            end
            MODE_CIRCLE: begin
                res_x = sx_e + cqx;
                res_y = sy_e + cqy;
            end
            MODE_MID: begin
                res_x = SUM_W'(side_e.mid_x);
                res_y = SUM_W'(side_e.mid_y);
            end
            default: begin
                res_x = sx_e;
                res_y = sy_e;
            end
        endcase
    end

    assign pt_x = sat_coord(res_x);
    assign pt_y = sat_coord(res_y);

endmodule

// ===== hdl/eecu_chk.sv =====
// ----------------------------------------------------------------------------
// eecu_chk
// Port-level checks on the edge endpoint clipper unit, bound to the top.
// ----------------------------------------------------------------------------
module eecu_chk import eecu_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [COORD_W-1:0] m_start_x,
    input logic signed [COORD_W-1:0] m_end_y
);

    // Hold a stalled result item
    a_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_start_x) && $stable(m_end_y))
        else $error("result item changed while stalled");

    // Reset empties the output
    a_reset : assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Empty output always takes an item
    a_take : assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // A held result freezes the pipe
    a_freeze : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result held");

endmodule

bind edge_endpoint_clipper_unit eecu_chk u_eecu_chk (.*);
